>>> hw/rtl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Types and constants shared by the fixed frame deframer
// ----------------------------------------------------------------------------
package ffd_pkg;

	localparam int unsigned WIN_LEN  = 16;
	localparam int unsigned FILL_W   = 4;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hEB;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h90;
	localparam logic [7:0] TAIL_FIRST_RST  = 8'hAA;
	localparam logic [7:0] TAIL_SECOND_RST = 8'h55;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_FIRST  = 8'd0,
		REG_SYNC_SECOND = 8'd1,
		REG_TAIL_FIRST  = 8'd2,
		REG_TAIL_SECOND = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic signed [31:0] value_one;
		logic signed [31:0] value_two;
		logic signed [31:0] value_three;
		logic [31:0]        frame_count;
	} frame_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           wr_data;
	} cfg_wr_t;

endpackage

>>> hw/rtl/ffd_stream_if.sv
// ----------------------------------------------------------------------------
// ffd_stream_if
// Valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface ffd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/fixed_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// fixed_frame_deframer_top
// Finds 16-byte frames in a byte stream and unpacks their three payload words
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while input ready is high. The window is
// a row of sixteen byte cells that shift on every byte transfer; the header
// and trailer are checked against the new byte and the cells in the same
// cycle, and a matched frame is registered into the result register or the
// skid entry. A result register plus one skid entry let bytes keep flowing
// while the result side stalls; input ready drops only when both are full.
// Configuration writes are always taken, and an index above three is ignored.
module fixed_frame_deframer_top (
	input  logic         clk,
	input  logic         arst_n,
	ffd_stream_if.sink   rx,
	ffd_stream_if.source result,
	ffd_stream_if.sink   cfg
);
	import ffd_pkg::*;

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic [7:0] tail_first_q;
	logic [7:0] tail_second_q;

	logic [FILL_W-1:0] fill_q;
	logic [31:0]       frames_q;
	logic [7:0]        win [WIN_LEN];
	logic              rx_xfer;
	logic              hit;
	logic              can_take;
	rx_item_t          rx_item;
	frame_t            frame;

	assign rx_item  = rx.data;
	assign rx.ready = can_take;
	assign rx_xfer  = rx.valid && can_take;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			tail_first_q  <= TAIL_FIRST_RST;
			tail_second_q <= TAIL_SECOND_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg.data.wr_data;
				REG_SYNC_SECOND: sync_second_q <= cfg.data.wr_data;
				REG_TAIL_FIRST:  tail_first_q  <= cfg.data.wr_data;
				REG_TAIL_SECOND: tail_second_q <= cfg.data.wr_data;
				default: ;
			endcase
		end
	end

	// when the last frame byte arrives, cell i holds frame offset i-1
	for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
		logic [7:0] d_in;
		if (i == WIN_LEN - 1) begin : g_last
			assign d_in = rx_item.rx_byte;
		end else begin : g_mid
			assign d_in = win[i+1];
		end
		ffd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (rx_xfer),
			.d_in   (d_in),
			.q      (win[i])
		);
	end

	assign hit = (fill_q == FILL_W'(WIN_LEN - 1))
		&& (win[1] == sync_first_q)
		&& (win[2] == sync_second_q)
		&& (win[WIN_LEN-1] == tail_first_q)
		&& (rx_item.rx_byte == tail_second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			frames_q <= '0;
		end else if (rx_xfer) begin
			if (fill_q != FILL_W'(WIN_LEN - 1)) begin
				fill_q <= fill_q + 1'b1;
			end else if (hit) begin
				fill_q   <= '0;
				frames_q <= frames_q + 32'd1;
			end
		end
	end

	assign frame.value_one   = {win[6], win[5], win[4], win[3]};
	assign frame.value_two   = {win[10], win[9], win[8], win[7]};
	assign frame.value_three = {win[14], win[13], win[12], win[11]};
	assign frame.frame_count = frames_q + 32'd1;

	ffd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rx_xfer && hit),
		.push_data (frame),
		.can_take  (can_take),
		.result    (result)
	);
endmodule

>>> hw/rtl/ffd_cell.sv
// ----------------------------------------------------------------------------
// ffd_cell
// One byte of the receive window, loads from its neighbor or the new byte on each shift
// ----------------------------------------------------------------------------
module ffd_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] d_in,
	output logic [7:0] q
);
	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d_in;
		end
	end

	assign q = byte_q;
endmodule

>>> hw/rtl/ffd_out_buf.sv
// ----------------------------------------------------------------------------
// ffd_out_buf
// Result register with a skid entry so the window keeps shifting on stalls
// ----------------------------------------------------------------------------
module ffd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ffd_pkg::frame_t     push_data,
	output logic                can_take,
	ffd_stream_if.source        result
);
	import ffd_pkg::*;

	logic   out_valid_q;
	frame_t out_q;
	logic   skid_valid_q;
	frame_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result.ready) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign can_take     = !skid_valid_q;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;
endmodule

>>> hw/rtl/ffd_checker.sv
// ----------------------------------------------------------------------------
// ffd_checker
// Port-level checks of the fixed frame deframer, bound to the top level
// ----------------------------------------------------------------------------
module ffd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rx_valid,
	input logic                 rx_ready,
	input logic                 res_valid,
	input logic                 res_ready,
	input ffd_pkg::frame_t      res_data,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);
	import ffd_pkg::*;

	logic [4:0]  bytes_q;
	logic        seen_q;
	logic [31:0] last_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
			seen_q  <= 1'b0;
		end else begin
			if (rx_valid && rx_ready && bytes_q != 5'(WIN_LEN)) begin
				bytes_q <= bytes_q + 1'b1;
			end
			if (res_valid && res_ready) begin
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			last_count_q <= res_data.frame_count;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_no_early_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> bytes_q == 5'(WIN_LEN))
		else $error("result before a full window was received");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && seen_q |-> res_data.frame_count == last_count_q + 32'd1)
		else $error("frame count did not advance by one");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write was not taken");

endmodule

bind fixed_frame_deframer_top ffd_checker u_ffd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx.valid),
	.rx_ready  (rx.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

>>> test/fixed_frame_deframer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_frame_deframer_top_tb
// Self-checking regression for the fixed frame deframer
// ----------------------------------------------------------------------------
// A short hand-written byte sequence covers a filling window, a slide past a
// junk byte and a frame carrying extreme payload words. Random traffic then
// follows: mostly well-formed frames with random payloads, plus noise and
// frames with a bad marker byte or cut short. The marker registers change
// between phases, and the sender and receiver idle in different patterns
// from phase to phase. Every byte transfer feeds a local frame search, and
// every result transfer is compared with the oldest frame it predicted.
// ----------------------------------------------------------------------------
module fixed_frame_deframer_top_tb;
	import ffd_pkg::*;

	localparam int PHASES      = 8;
	localparam int RAND_ITEMS  = 1250;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DIR_ROWS    = 22;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       pinned;
		logic       hit;
		frame_t     frame;
	} dir_row_t;

	localparam frame_t NO_FRAME = '0;

	// pinned rows carry their result typed in, the rest go through the frame search
	localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
		'{8'h00,           1'b1, 1'b0, NO_FRAME},
		'{SYNC_FIRST_RST,  1'b1, 1'b0, NO_FRAME},
		'{SYNC_SECOND_RST, 1'b1, 1'b0, NO_FRAME},
		'{8'hFF,           1'b1, 1'b0, NO_FRAME},
		'{8'hFF,           1'b1, 1'b0, NO_FRAME},
		'{8'hFF,           1'b1, 1'b0, NO_FRAME},
		'{8'h7F,           1'b1, 1'b0, NO_FRAME},
		'{8'h00,           1'b1, 1'b0, NO_FRAME},
		'{8'h00,           1'b1, 1'b0, NO_FRAME},
		'{8'h00,           1'b1, 1'b0, NO_FRAME},
		'{8'h80,           1'b1, 1'b0, NO_FRAME},
		'{8'h01,           1'b1, 1'b0, NO_FRAME},
		'{8'h02,           1'b1, 1'b0, NO_FRAME},
		'{8'h03,           1'b1, 1'b0, NO_FRAME},
		'{8'h04,           1'b1, 1'b0, NO_FRAME},
		'{TAIL_FIRST_RST,  1'b1, 1'b0, NO_FRAME},
		'{TAIL_SECOND_RST, 1'b1, 1'b1,
			'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0403_0201, 32'd1}},
		'{SYNC_FIRST_RST,  1'b0, 1'b0, NO_FRAME},
		'{SYNC_SECOND_RST, 1'b0, 1'b0, NO_FRAME},
		'{8'h5A,           1'b0, 1'b0, NO_FRAME},
		'{8'hA5,           1'b0, 1'b0, NO_FRAME},
		'{8'hC3,           1'b0, 1'b0, NO_FRAME}
	};

	logic clk;
	logic arst_n;

	ffd_stream_if #(.payload_t(rx_item_t)) rx_if ();
	ffd_stream_if #(.payload_t(frame_t))   result_if ();
	ffd_stream_if #(.payload_t(cfg_wr_t))  cfg_if ();

	fixed_frame_deframer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// frame search state and marker registers as the block should hold them
	logic [7:0]  hdr0 = SYNC_FIRST_RST;
	logic [7:0]  hdr1 = SYNC_SECOND_RST;
	logic [7:0]  trl0 = TAIL_FIRST_RST;
	logic [7:0]  trl1 = TAIL_SECOND_RST;
	logic [7:0]  win_bytes [WIN_LEN] = '{default: 8'h00};
	int unsigned win_count = 0;
	logic [31:0] frames_seen = '0;

	frame_t      pending_frames [$];
	int          bytes_taken = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;

	function automatic logic deframe_byte(input logic [7:0] b, output frame_t f);
		f = '0;
		win_bytes[win_count] = b;
		win_count++;
		if (win_count < WIN_LEN)
			return 1'b0;
		if (win_bytes[0] != hdr0 || win_bytes[1] != hdr1 ||
		    win_bytes[WIN_LEN-2] != trl0 || win_bytes[WIN_LEN-1] != trl1) begin
			for (int i = 0; i < WIN_LEN - 1; i++)
				win_bytes[i] = win_bytes[i+1];
			win_count = WIN_LEN - 1;
			return 1'b0;
		end
		frames_seen++;
		f.value_one   = {win_bytes[5], win_bytes[4], win_bytes[3], win_bytes[2]};
		f.value_two   = {win_bytes[9], win_bytes[8], win_bytes[7], win_bytes[6]};
		f.value_three = {win_bytes[13], win_bytes[12], win_bytes[11], win_bytes[10]};
		f.frame_count = frames_seen;
		win_count = 0;
		return 1'b1;
	endfunction

	task automatic check_word(input string field, input logic [31:0] want, got);
		if (want !== got) begin
			$error("%s: expected 0x%08h, got 0x%08h", field, want, got);
			fail_count++;
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid        <= 1'b1;
		rx_if.data.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
	endtask

	// leaves valid high so that writes can follow back to back
	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		cfg_if.valid        <= 1'b1;
		cfg_if.data.index   <= idx;
		cfg_if.data.wr_data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_if.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fixed_frame_deframer_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		frame_t f;
		frame_t want;
		logic   hit;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.data.index)
					REG_SYNC_FIRST:  hdr0 = cfg_if.data.wr_data;
					REG_SYNC_SECOND: hdr1 = cfg_if.data.wr_data;
					REG_TAIL_FIRST:  trl0 = cfg_if.data.wr_data;
					REG_TAIL_SECOND: trl1 = cfg_if.data.wr_data;
					default: ;
				endcase
			end
			if (rx_if.valid && rx_if.ready) begin
				hit = deframe_byte(rx_if.data.rx_byte, f);
				if (bytes_taken < DIR_ROWS && DIR_TBL[bytes_taken].pinned) begin
					hit = DIR_TBL[bytes_taken].hit;
					f   = DIR_TBL[bytes_taken].frame;
				end
				if (hit)
					pending_frames.push_back(f);
				bytes_taken++;
			end
			if (result_if.valid && result_if.ready) begin
				if (pending_frames.size() == 0) begin
					$error("frame transfer with none expected, frame_count %0d",
						result_if.data.frame_count);
					fail_count++;
				end else begin
					want = pending_frames.pop_front();
					check_word("value_one", want.value_one, result_if.data.value_one);
					check_word("value_two", want.value_two, result_if.data.value_two);
					check_word("value_three", want.value_three, result_if.data.value_three);
					check_word("frame_count", want.frame_count, result_if.data.frame_count);
				end
			end
		end
	end

	initial begin
		logic [7:0] cfg_vals [4];
		logic [7:0] seq [$];
		int         sent;
		int         kind;
		int         pos;
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.data    = '0;
		cfg_if.valid  = 1'b0;
		cfg_if.data   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// index past the last register must leave the reset markers alone
		write_reg(8'($urandom_range(255, REG_TAIL_SECOND + 1)), 8'($urandom));
		cfg_if.valid <= 1'b0;

		for (int i = 0; i < DIR_ROWS; i++)
			push_byte(DIR_TBL[i].rx_byte);

		for (int phase = 0; phase < PHASES; phase++) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
			while (pending_frames.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);

			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
				default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
			endcase

			if (phase > 0) begin
				case (phase)
					1: cfg_vals = '{8'h00, 8'h00, 8'h00, 8'h00};
					2: cfg_vals = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
					3: cfg_vals = '{8'h00, 8'hFF, 8'hFF, 8'h00};
					default: foreach (cfg_vals[r]) cfg_vals[r] = 8'($urandom);
				endcase
				for (int r = REG_SYNC_FIRST; r <= REG_TAIL_SECOND; r++)
					write_reg(8'(r), cfg_vals[r]);
				write_reg(8'($urandom_range(255, REG_TAIL_SECOND + 1)), 8'($urandom));
				cfg_if.valid <= 1'b0;
				@(posedge clk);
			end

			sent = 0;
			while (sent < RAND_ITEMS / PHASES) begin
				seq  = {};
				kind = $urandom_range(99);
				if (kind >= 70 && kind < 85) begin
					repeat ($urandom_range(8, 1)) seq.push_back(8'($urandom));
				end else begin
					seq.push_back(hdr0);
					seq.push_back(hdr1);
					repeat (12) seq.push_back(8'($urandom));
					seq.push_back(trl0);
					seq.push_back(trl1);
					if (kind >= 85) begin
						if ($urandom_range(1) == 1) begin
							// corrupt a header or trailer byte
							pos = $urandom_range(3);
							if (pos >= 2)
								pos = pos + WIN_LEN - 4;
							seq[pos] = seq[pos] ^ 8'($urandom_range(255, 1));
						end else begin
							repeat ($urandom_range(15, 1)) void'(seq.pop_back());
						end
					end
				end
				foreach (seq[k])
					push_byte(seq[k]);
				sent += seq.size();
			end
		end

		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("fixed_frame_deframer_top regression: pass");
		else
			$display("fixed_frame_deframer_top regression: fail");
		$finish;
	end

endmodule
